// File: sv/pfse_pkg.sv
// Shared types and codes for the prime factor sieve engine.
// No dependencies; imported by prime_factor_sieve_engine.
`timescale 1ns / 1ps

package pfse_pkg;

  localparam int unsigned CFG_W = 18;
  localparam int unsigned VAL_W = 32;
  localparam logic [CFG_W-1:0] LIMIT_RESET = 18'd131072;

  typedef enum logic [2:0] {
    CMD_BUILD    = 3'd0,
    CMD_SMALL    = 3'd1,
    CMD_ALL      = 3'd2,
    CMD_DISTINCT = 3'd3,
    CMD_TOTIENT  = 3'd4
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_UNRES    = 2'd1,
    ST_NOTBUILT = 2'd2,
    ST_NOFACT   = 2'd3
  } status_e;

  typedef struct packed {
    logic [2:0]       cmd;
    logic [VAL_W-1:0] query_value;
  } in_t;

  typedef struct packed {
    logic [VAL_W-1:0] result_value;
    logic             last;
    logic [1:0]       status;
  } out_t;

endpackage

// File: sv/prime_factor_sieve_engine.sv
// Prime factor sieve engine: linear sieve table build plus factor queries.
// Build: clear each covered entry (limit/2, up to ODD_ENTRIES), then sieve each table
// entry and mark its multiples.
// Query: per factor, fetch it from the table, plus one pass of the shared divider per
// division by it; totient adds one more pass per distinct factor. Each stored prime tried
// by trial division costs one divider pass.
// One item at a time; in_ready_o is high only while idle. Reset empties the table
// state (no table is built yet, so queries report status 2); no clearing pass.
`timescale 1ns / 1ps

module prime_factor_sieve_engine
  import pfse_pkg::*;
#(
  parameter int unsigned ODD_ENTRIES = 65536,
  parameter int unsigned PRIME_SLOTS = 16384,
  parameter int unsigned VALUE_BITS  = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [CFG_W-1:0] cfg_data_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  in_t              in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output out_t             out_data_o
);

  // index bits, stored-number bits, limit bits, value bits, arithmetic bits
  localparam int unsigned IW       = $clog2(ODD_ENTRIES);
  localparam int unsigned NW       = IW + 1;
  localparam int unsigned LW       = (NW + 1 > CFG_W) ? NW + 1 : CFG_W;
  localparam int unsigned VW       = (VALUE_BITS < VAL_W) ? VALUE_BITS : VAL_W;
  localparam int unsigned AW       = (VW > NW) ? VW : NW;
  localparam int unsigned WW       = (VW > LW) ? VW : LW;
  localparam int unsigned LIST_CAP = (PRIME_SLOTS < 32767) ? PRIME_SLOTS : 32767;
  localparam int unsigned CW       = $clog2(LIST_CAP + 1);
  localparam int unsigned PSW      = $clog2(PRIME_SLOTS);
  localparam int unsigned LMAX     = 2 * ODD_ENTRIES;

  typedef enum logic [4:0] {
    S_IDLE, S_CLR, S_BRD, S_BCHK, S_JRD, S_JCMP, S_JWR,
    S_TWO, S_LOOP, S_LGOT, S_TRD, S_TP, S_TDIV, S_FDONE,
    S_DWAIT, S_RWAIT, S_RMUL, S_EMIT, S_FLUSH
  } state_e;

  state_e           state_q, ret_q;
  logic [CFG_W-1:0] limit_q;
  logic [LW-1:0]    lim_q, blimit_q;
  logic             built_q;
  logic [CW-1:0]    total_q, j_q;
  logic [NW-1:0]    i_q, fi_q;
  logic [2:0]       cmd_q;
  logic [VW-1:0]    v_q, r_q;
  logic [AW-1:0]    f_q, p_q;
  logic             even_q;
  logic [VAL_W-1:0] em_val_q, pend_val_q;
  status_e          em_st_q, pend_st_q;
  logic             pend_v_q;
  logic             out_v_q;
  out_t             out_q;

  // storage: smallest factor of 2i+1, and odd primes in order (slot 0 unused)
  logic [NW-1:0] tbl_mem [ODD_ENTRIES];
  logic [NW-1:0] lst_mem [PRIME_SLOTS];
  logic [NW-1:0] tbl_rd_q, lst_rd_q;

  logic            tbl_we, lst_we;
  logic [IW-1:0]   tbl_wa, tbl_ra;
  logic [NW-1:0]   tbl_wd;
  logic [PSW-1:0]  lst_wa, lst_ra;

  logic            div_go, div_done;
  logic [AW-1:0]   div_a, div_b, div_q, div_r;
  logic [AW-1:0]   mul_a, mul_b;
  logic [2*AW-1:0] prod_q;

  logic [LW-1:0]   cfg_ext, lim_c, half;
  logic [NW-1:0]   num;
  logic            out_free;
  logic            out_push, out_last;
  logic [VW-1:0]   qv;
  logic            prod_fits;

  assign cfg_ext   = LW'(limit_q);
  assign lim_c     = (cfg_ext < LW'(3)) ? LW'(3) :
                     ((cfg_ext > LW'(LMAX)) ? LW'(LMAX) : cfg_ext);
  assign half      = lim_q >> 1;
  assign num       = {i_q[IW-1:0], 1'b1};
  assign out_free  = !out_v_q || out_ready_i;
  assign qv        = in_data_i.query_value[VW-1:0];
  assign prod_fits = prod_q < (2*AW)'(lim_q);

  // move the held-back item to the output register; the flush carries last
  assign out_push  = pend_v_q && out_free && (state_q == S_EMIT || state_q == S_FLUSH);
  assign out_last  = state_q == S_FLUSH;

  pfse_div #(.W(AW)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_go),
    .dividend_i (div_a),
    .divisor_i  (div_b),
    .done_o     (div_done),
    .quot_o     (div_q),
    .rem_o      (div_r)
  );

  // shared multiplier: sieve multiples during build, totient step during queries
  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
  end

  always_ff @(posedge clk_i) begin
    if (tbl_we) tbl_mem[tbl_wa] <= tbl_wd;
    tbl_rd_q <= tbl_mem[tbl_ra];
  end

  always_ff @(posedge clk_i) begin
    if (lst_we) lst_mem[lst_wa] <= num;
    lst_rd_q <= lst_mem[lst_ra];
  end

  // memory ports and shared-unit operands, steered by the sequencer state
  always_comb begin
    tbl_we = 1'b0;
    tbl_wa = i_q[IW-1:0];
    tbl_wd = '0;
    tbl_ra = i_q[IW-1:0];
    lst_we = 1'b0;
    lst_wa = PSW'(total_q);
    lst_ra = PSW'(j_q);
    div_go = 1'b0;
    div_a  = AW'(v_q);
    div_b  = f_q;
    mul_a  = div_q;
    mul_b  = f_q - AW'(1);
    unique case (state_q)
      S_CLR: tbl_we = LW'(i_q) < half;
      S_BCHK: begin
        if (tbl_rd_q == '0) begin
          tbl_we = 1'b1;
          tbl_wd = num;
          lst_we = total_q < CW'(LIST_CAP);
        end
      end
      S_JCMP: begin
        mul_a = AW'(num);
        mul_b = AW'(lst_rd_q);
      end
      S_JWR: begin
        if (prod_fits) begin
          tbl_we = 1'b1;
          tbl_wa = IW'(prod_q >> 1);
          tbl_wd = p_q[NW-1:0];
        end
      end
      S_LOOP: tbl_ra = IW'(v_q >> 1);
      S_TP: begin
        div_go = lst_rd_q >= NW'(2);
        div_b  = AW'(lst_rd_q);
      end
      S_FDONE: div_go = cmd_q != CMD_SMALL;
      S_DWAIT: begin
        if (div_done && cmd_q != CMD_ALL) begin
          if (div_r == '0) begin
            div_go = 1'b1;
            div_a  = div_q;
          end else if (cmd_q == CMD_TOTIENT) begin
            div_go = 1'b1;
            div_a  = AW'(r_q);
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      ret_q      <= S_IDLE;
      limit_q    <= LIMIT_RESET;
      lim_q      <= '0;
      blimit_q   <= '0;
      built_q    <= 1'b0;
      total_q    <= '0;
      j_q        <= '0;
      i_q        <= '0;
      fi_q       <= '0;
      cmd_q      <= '0;
      v_q        <= '0;
      r_q        <= '0;
      f_q        <= '0;
      p_q        <= '0;
      even_q     <= 1'b0;
      em_val_q   <= '0;
      em_st_q    <= ST_OK;
      pend_val_q <= '0;
      pend_st_q  <= ST_OK;
      pend_v_q   <= 1'b0;
      out_v_q    <= 1'b0;
      out_q      <= '0;
    end else begin
      if (cfg_we_i) limit_q <= cfg_data_i;
      if (out_push) begin
        out_q   <= '{result_value: pend_val_q, last: out_last, status: pend_st_q};
        out_v_q <= 1'b1;
      end else if (out_ready_i) begin
        out_v_q <= 1'b0;
      end

      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            cmd_q  <= in_data_i.cmd;
            v_q    <= qv;
            r_q    <= qv;
            even_q <= 1'b0;
            ret_q  <= S_FLUSH;
            unique case (in_data_i.cmd) inside
              CMD_BUILD: begin
                lim_q   <= lim_c;
                i_q     <= '0;
                state_q <= S_CLR;
              end
              CMD_SMALL, CMD_ALL, CMD_DISTINCT, CMD_TOTIENT: begin
                if (!built_q) begin
                  em_val_q <= '0;
                  em_st_q  <= ST_NOTBUILT;
                  state_q  <= S_EMIT;
                end else if (qv < VW'(2)) begin
                  em_val_q <= '0;
                  em_st_q  <= ST_NOFACT;
                  state_q  <= S_EMIT;
                end else if (in_data_i.cmd == CMD_SMALL) begin
                  if (!qv[0]) begin
                    em_val_q <= VAL_W'(2);
                    em_st_q  <= ST_OK;
                    state_q  <= S_EMIT;
                  end else begin
                    state_q <= S_LOOP;
                  end
                end else begin
                  state_q <= S_TWO;
                end
              end
              default: state_q <= S_FLUSH;
            endcase
          end
        end

        // build: clear the covered entries, then sieve entry by entry
        S_CLR: begin
          if (LW'(i_q) < half) begin
            i_q <= i_q + NW'(1);
          end else begin
            i_q     <= NW'(1);
            total_q <= CW'(1);
            state_q <= S_BRD;
          end
        end
        S_BRD: begin
          if (LW'(i_q) >= half) begin
            blimit_q <= lim_q;
            built_q  <= 1'b1;
            em_val_q <= VAL_W'(total_q);
            em_st_q  <= ST_OK;
            ret_q    <= S_FLUSH;
            state_q  <= S_EMIT;
          end else begin
            state_q <= S_BCHK;
          end
        end
        S_BCHK: begin
          fi_q <= (tbl_rd_q == '0) ? num : tbl_rd_q;
          if (tbl_rd_q == '0 && total_q < CW'(LIST_CAP)) total_q <= total_q + CW'(1);
          j_q     <= CW'(1);
          state_q <= S_JRD;
        end
        S_JRD: begin
          if (j_q >= total_q) begin
            i_q     <= i_q + NW'(1);
            state_q <= S_BRD;
          end else begin
            state_q <= S_JCMP;
          end
        end
        S_JCMP: begin
          if (lst_rd_q > fi_q) begin
            i_q     <= i_q + NW'(1);
            state_q <= S_BRD;
          end else begin
            p_q     <= AW'(lst_rd_q);
            state_q <= S_JWR;
          end
        end
        S_JWR: begin
          if (prod_fits) begin
            j_q     <= j_q + CW'(1);
            state_q <= S_JRD;
          end else begin
            i_q     <= i_q + NW'(1);
            state_q <= S_BRD;
          end
        end

        // queries: strip factors of two first
        S_TWO: begin
          if (!v_q[0]) begin
            v_q    <= v_q >> 1;
            even_q <= 1'b1;
            if (cmd_q == CMD_ALL || (cmd_q == CMD_DISTINCT && !even_q)) begin
              em_val_q <= VAL_W'(2);
              em_st_q  <= ST_OK;
              ret_q    <= S_TWO;
              state_q  <= S_EMIT;
            end else if (cmd_q == CMD_TOTIENT && !even_q) begin
              r_q <= r_q >> 1;
            end
          end else begin
            state_q <= S_LOOP;
          end
        end
        S_LOOP: begin
          if (v_q == VW'(1)) begin
            if (cmd_q == CMD_TOTIENT) begin
              em_val_q <= VAL_W'(r_q);
              em_st_q  <= ST_OK;
              ret_q    <= S_FLUSH;
              state_q  <= S_EMIT;
            end else begin
              state_q <= S_FLUSH;
            end
          end else if (WW'(v_q) < WW'(blimit_q)) begin
            state_q <= S_LGOT;
          end else begin
            j_q     <= CW'(1);
            state_q <= S_TRD;
          end
        end
        S_LGOT: begin
          f_q     <= (tbl_rd_q < NW'(2)) ? AW'(v_q) : AW'(tbl_rd_q);
          state_q <= S_FDONE;
        end

        // trial division by the stored primes
        S_TRD: begin
          if (j_q >= total_q) begin
            em_val_q <= VAL_W'(v_q);
            em_st_q  <= ST_UNRES;
            ret_q    <= S_FLUSH;
            state_q  <= S_EMIT;
          end else begin
            state_q <= S_TP;
          end
        end
        S_TP: begin
          if (lst_rd_q < NW'(2)) begin
            j_q     <= j_q + CW'(1);
            state_q <= S_TRD;
          end else begin
            p_q     <= AW'(lst_rd_q);
            state_q <= S_TDIV;
          end
        end
        S_TDIV: begin
          if (div_done) begin
            // quotient below p means p*p exceeds the value
            if (div_r == '0) begin
              f_q     <= p_q;
              state_q <= S_FDONE;
            end else if (div_q < p_q) begin
              f_q     <= AW'(v_q);
              state_q <= S_FDONE;
            end else begin
              j_q     <= j_q + CW'(1);
              state_q <= S_TRD;
            end
          end
        end

        S_FDONE: begin
          if (cmd_q == CMD_SMALL) begin
            em_val_q <= VAL_W'(f_q);
            em_st_q  <= ST_OK;
            ret_q    <= S_FLUSH;
            state_q  <= S_EMIT;
          end else begin
            state_q <= S_DWAIT;
          end
        end
        S_DWAIT: begin
          if (div_done) begin
            if (cmd_q == CMD_ALL) begin
              v_q      <= VW'(div_q);
              em_val_q <= VAL_W'(f_q);
              em_st_q  <= ST_OK;
              ret_q    <= S_LOOP;
              state_q  <= S_EMIT;
            end else if (div_r == '0) begin
              v_q <= VW'(div_q);
            end else if (cmd_q == CMD_DISTINCT) begin
              em_val_q <= VAL_W'(f_q);
              em_st_q  <= ST_OK;
              ret_q    <= S_LOOP;
              state_q  <= S_EMIT;
            end else begin
              state_q <= S_RWAIT;
            end
          end
        end
        S_RWAIT: begin
          if (div_done) state_q <= S_RMUL;
        end
        S_RMUL: begin
          r_q     <= VW'(prod_q);
          state_q <= S_LOOP;
        end

        // hold one item back so the final one can carry last
        S_EMIT: begin
          if (!pend_v_q) begin
            pend_val_q <= em_val_q;
            pend_st_q  <= em_st_q;
            pend_v_q   <= 1'b1;
            state_q    <= ret_q;
          end else if (out_free) begin
            pend_val_q <= em_val_q;
            pend_st_q  <= em_st_q;
            state_q    <= ret_q;
          end
        end
        S_FLUSH: begin
          if (!pend_v_q) begin
            state_q <= S_IDLE;
          end else if (out_free) begin
            pend_v_q <= 1'b0;
            state_q  <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_ready_o  = state_q == S_IDLE;
  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

endmodule

// File: sv/pfse_div.sv
// Iterative restoring divider, one quotient bit per cycle.
// Uses no package items; instantiated by prime_factor_sieve_engine.
`timescale 1ns / 1ps

module pfse_div #(
  parameter int unsigned W = 32
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [W-1:0] dividend_i,
  input  logic [W-1:0] divisor_i,
  output logic         done_o,
  output logic [W-1:0] quot_o,
  output logic [W-1:0] rem_o
);

  localparam int unsigned CNT_W = $clog2(W + 1);

  logic [CNT_W-1:0] cnt_q;
  logic             run_q, done_q;
  logic [W-1:0]     quo_q, dvs_q;
  logic [W:0]       rem_q;
  logic [W:0]       shifted;
  logic             fits;

  assign shifted = {rem_q[W-1:0], quo_q[W-1]};
  assign fits    = shifted >= {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      run_q  <= 1'b0;
      done_q <= 1'b0;
      quo_q  <= '0;
      dvs_q  <= '0;
      rem_q  <= '0;
    end else if (start_i) begin
      cnt_q  <= CNT_W'(W);
      run_q  <= 1'b1;
      done_q <= 1'b0;
      quo_q  <= dividend_i;
      dvs_q  <= divisor_i;
      rem_q  <= '0;
    end else if (run_q) begin
      // shift in one dividend bit, subtract when it fits
      rem_q <= fits ? (shifted - {1'b0, dvs_q}) : shifted;
      quo_q <= {quo_q[W-2:0], fits};
      cnt_q <= cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        run_q  <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;
  assign rem_o  = rem_q[W-1:0];

endmodule
